// ----- sv/cpc_pkg.sv -----
// shared types, pattern codes and confidence table for the candlestick classifier
package cpc_pkg;

	localparam int PRICE_BITS_DEFAULT  = 32;
	localparam int QUEUE_DEPTH_DEFAULT = 4;
	localparam int NUM_PATTERNS        = 10;
	localparam int FIELD_BITS          = 32;

	localparam logic [3:0] PAT_DOJI      = 4'd0;
	localparam logic [3:0] PAT_HAMMER    = 4'd1;
	localparam logic [3:0] PAT_SHOOTING  = 4'd2;
	localparam logic [3:0] PAT_BULL_ENG  = 4'd3;
	localparam logic [3:0] PAT_BEAR_ENG  = 4'd4;
	localparam logic [3:0] PAT_WHITE_MAR = 4'd5;
	localparam logic [3:0] PAT_BLACK_MAR = 4'd6;
	localparam logic [3:0] PAT_SPIN_TOP  = 4'd7;
	localparam logic [3:0] PAT_MORN_STAR = 4'd8;
	localparam logic [3:0] PAT_SOLDIERS  = 4'd9;

	typedef struct packed {
		logic        starts_series;
		logic [31:0] bar_date;
		logic [31:0] open_price;
		logic [31:0] high_price;
		logic [31:0] low_price;
		logic [31:0] close_price;
	} bar_item_t;

	typedef struct packed {
		logic [31:0] match_date;
		logic [3:0]  pattern_code;
		logic [6:0]  confidence;
		logic        last_of_bar;
	} result_item_t;

	typedef logic [NUM_PATTERNS-1:0] pat_mask_t;

	// one queue entry: the date of a bar and the set of patterns it completed
	typedef struct packed {
		logic [31:0] date;
		pat_mask_t   mask;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [6:0] conf_of(input logic [3:0] code);
		logic [6:0] c;
		unique case (code)
			PAT_DOJI:      c = 7'd60;
			PAT_HAMMER:    c = 7'd70;
			PAT_SHOOTING:  c = 7'd70;
			PAT_BULL_ENG:  c = 7'd80;
			PAT_BEAR_ENG:  c = 7'd80;
			PAT_WHITE_MAR: c = 7'd65;
			PAT_BLACK_MAR: c = 7'd65;
			PAT_SPIN_TOP:  c = 7'd50;
			PAT_MORN_STAR: c = 7'd85;
			PAT_SOLDIERS:  c = 7'd90;
			default:       c = 7'd0;
		endcase
		return c;
	endfunction

endpackage

// ----- sv/cpc_front.sv -----
// front end: bar history, two-stage pattern tests, pushes match sets into the queue
module cpc_front import cpc_pkg::*; #(
	parameter int PRICE_BITS = PRICE_BITS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      bar_valid,
	output logic      bar_ready,
	input  bar_item_t bar,
	input  q_status_t qstat,
	output logic      push,
	output q_entry_t  push_data
);

	localparam int PW = (PRICE_BITS < FIELD_BITS) ? PRICE_BITS : FIELD_BITS;
	localparam int DW = PW + 6;

	typedef logic [PW-1:0]        price_t;
	typedef logic signed [DW-1:0] wide_t;

	function automatic wide_t wx(input price_t u);
		return wide_t'({{(DW-PW){1'b0}}, u});
	endfunction

	// history
	logic [1:0] seen_q;
	price_t     prv_op_q, prv_hi_q, prv_lo_q, prv_cl_q;
	price_t     old_op_q, old_cl_q;

	// stage 1 registers
	logic        valid_s1;
	logic        test_s1;
	logic [31:0] date_s1;
	wide_t       body_s1, range_s1, lower_s1, upper_s1, pbody_s1, prange_s1;
	logic        rise_s1, fall_s1, bull_s1, bear_s1, morn_s1, sold_s1;

	logic      xfer;
	price_t    c_op, c_hi, c_lo, c_cl;
	wide_t     op_w, hi_w, lo_w, cl_w, pop_w, phi_w, plo_w, pcl_w, oop_w, ocl_w;
	wide_t     body_c, range_c, lower_c, upper_c, pbody_c, prange_c;
	logic      test_c;
	pat_mask_t mask;
	logic      s1_done;

	wide_t b2, b10, r3, r9, l10, u10, pb10, pr3;

	assign xfer = bar_valid && bar_ready;
	assign c_op = bar.open_price[PW-1:0];
	assign c_hi = bar.high_price[PW-1:0];
	assign c_lo = bar.low_price[PW-1:0];
	assign c_cl = bar.close_price[PW-1:0];
	assign test_c = !bar.starts_series && (seen_q == 2'd2);

	always_comb begin
		op_w  = wx(c_op);
		hi_w  = wx(c_hi);
		lo_w  = wx(c_lo);
		cl_w  = wx(c_cl);
		pop_w = wx(prv_op_q);
		phi_w = wx(prv_hi_q);
		plo_w = wx(prv_lo_q);
		pcl_w = wx(prv_cl_q);
		oop_w = wx(old_op_q);
		ocl_w = wx(old_cl_q);
		body_c   = (cl_w >= op_w) ? (cl_w - op_w) : (op_w - cl_w);
		range_c  = hi_w - lo_w;
		lower_c  = ((cl_w < op_w) ? cl_w : op_w) - lo_w;
		upper_c  = hi_w - ((cl_w > op_w) ? cl_w : op_w);
		pbody_c  = (pcl_w >= pop_w) ? (pcl_w - pop_w) : (pop_w - pcl_w);
		prange_c = phi_w - plo_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= 2'd0;
			prv_op_q <= '0;
			prv_hi_q <= '0;
			prv_lo_q <= '0;
			prv_cl_q <= '0;
			old_op_q <= '0;
			old_cl_q <= '0;
		end else if (xfer) begin
			old_op_q <= bar.starts_series ? '0 : prv_op_q;
			old_cl_q <= bar.starts_series ? '0 : prv_cl_q;
			prv_op_q <= c_op;
			prv_hi_q <= c_hi;
			prv_lo_q <= c_lo;
			prv_cl_q <= c_cl;
			if (bar.starts_series) begin
				seen_q <= 2'd1;
			end else if (seen_q != 2'd2) begin
				seen_q <= seen_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bar_ready) begin
			valid_s1 <= bar_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			test_s1   <= test_c;
			date_s1   <= bar.bar_date;
			body_s1   <= body_c;
			range_s1  <= range_c;
			lower_s1  <= lower_c;
			upper_s1  <= upper_c;
			pbody_s1  <= pbody_c;
			prange_s1 <= prange_c;
			rise_s1   <= cl_w > op_w;
			fall_s1   <= cl_w < op_w;
			bull_s1   <= (pcl_w < pop_w) && (cl_w > op_w) && (op_w < pcl_w) && (cl_w > pop_w);
			bear_s1   <= (pcl_w > pop_w) && (cl_w < op_w) && (op_w > pcl_w) && (cl_w < pop_w);
			morn_s1   <= (ocl_w < oop_w) && (cl_w > op_w) && ((cl_w <<< 1) > (oop_w + ocl_w));
			sold_s1   <= (ocl_w > oop_w) && (pcl_w > pop_w) && (cl_w > op_w)
				&& (pcl_w > ocl_w) && (cl_w > pcl_w) && (pop_w > oop_w) && (pop_w < ocl_w)
				&& (op_w > pop_w) && (op_w < pcl_w);
		end
	end

	// stage 2: scaled compares as shift-add multiples
	always_comb begin
		b2   = body_s1 <<< 1;
		b10  = (body_s1 <<< 3) + (body_s1 <<< 1);
		r3   = (range_s1 <<< 1) + range_s1;
		r9   = (range_s1 <<< 3) + range_s1;
		l10  = (lower_s1 <<< 3) + (lower_s1 <<< 1);
		u10  = (upper_s1 <<< 3) + (upper_s1 <<< 1);
		pb10 = (pbody_s1 <<< 3) + (pbody_s1 <<< 1);
		pr3  = (prange_s1 <<< 1) + prange_s1;
		mask = '0;
		mask[PAT_DOJI]      = (range_s1 > 0) && (b10 <= range_s1);
		mask[PAT_HAMMER]    = (range_s1 > 0) && (lower_s1 >= b2) && (u10 <= body_s1);
		mask[PAT_SHOOTING]  = (range_s1 > 0) && (upper_s1 >= b2) && (l10 <= body_s1);
		mask[PAT_BULL_ENG]  = bull_s1;
		mask[PAT_BEAR_ENG]  = bear_s1;
		mask[PAT_WHITE_MAR] = (range_s1 > 0) && (b10 > r9) && rise_s1;
		mask[PAT_BLACK_MAR] = (range_s1 > 0) && (b10 > r9) && fall_s1;
		mask[PAT_SPIN_TOP]  = (range_s1 > 0) && (b10 < r3) && (lower_s1 > body_s1)
			&& (upper_s1 > body_s1);
		mask[PAT_MORN_STAR] = morn_s1 && (pb10 < pr3);
		mask[PAT_SOLDIERS]  = sold_s1;
		if (!test_s1) begin
			mask = '0;
		end
	end

	// a bar with no match leaves without a queue slot
	assign push           = valid_s1 && (mask != '0) && !qstat.full;
	assign s1_done        = valid_s1 && ((mask == '0) || !qstat.full);
	assign bar_ready      = !valid_s1 || s1_done;
	assign push_data.date = date_s1;
	assign push_data.mask = mask;

endmodule

// ----- sv/cpc_queue.sv -----
// short fifo of per-bar match sets between front and back
module cpc_queue import cpc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_entry_t  push_data,
	input  logic      pop,
	output q_status_t qstat,
	output q_entry_t  head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	q_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = mem_q[rd_q];

endmodule

// ----- sv/cpc_back.sv -----
// back end: walks the head match set, one result per cycle unless stalled
module cpc_back import cpc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  q_status_t    qstat,
	input  q_entry_t     head,
	output logic         pop,
	output logic         result_valid,
	input  logic         result_ready,
	output result_item_t result
);

	logic         out_valid_q;
	result_item_t out_q;
	pat_mask_t    done_q;
	pat_mask_t    pending, pick;
	logic [3:0]   code;
	logic         last, load;

	// lowest pending pattern goes first
	always_comb begin
		pending = head.mask & ~done_q;
		code    = PAT_DOJI;
		for (int i = NUM_PATTERNS - 1; i >= 0; i--) begin
			if (pending[i]) begin
				code = 4'(i);
			end
		end
		pick       = '0;
		pick[code] = 1'b1;
		last       = (pending & ~pick) == '0;
	end

	assign load = !qstat.empty && (!out_valid_q || result_ready);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				done_q      <= last ? '0 : (done_q | pick);
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.match_date   <= head.date;
			out_q.pattern_code <= code;
			out_q.confidence   <= conf_of(code);
			out_q.last_of_bar  <= last;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_code_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.pattern_code < 4'(NUM_PATTERNS)))
		else $error("pattern code out of range");

	a_done_subset: assert property (@(posedge clk) disable iff (!arst_n)
		!qstat.empty |-> ((done_q & ~head.mask) == '0))
		else $error("emitted set not within head match set");

	a_pending_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!qstat.empty |-> (pending != '0))
		else $error("queue head has nothing left to emit");

	a_pop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (done_q == '0))
		else $error("emitted set not cleared after pop");

endmodule

// ----- sv/candlestick_pattern_classifier_top.sv -----
// top level of the candlestick pattern classifier
//
// bar channel (bar_valid / bar_ready / bar): one price bar per transfer.
// starts_series restarts the two-bar history; that bar is stored, not tested.
// from the third bar of a series on, ten patterns are tested on each bar.
// result channel (result_valid / result_ready / result): one transfer per
// matching pattern, lowest pattern code first, last_of_bar set on the final
// one of a bar. a bar that matches nothing produces no transfer.
// latency: the first result of a bar is registered in stage 1, goes through
// the scaled compares into the queue, and from the queue into the output
// register.
// throughput: a bar is taken every cycle while the queue has room; the back
// end sends one result per cycle while result_ready is high, so the
// sustained rate is set by the match count per bar.
// when the receiver stalls, the output register holds its result, the queue
// of QUEUE_DEPTH match sets fills and then bar_ready drops.
// reset (arst_n low) empties the queue and output, zeroes history.
module candlestick_pattern_classifier_top import cpc_pkg::*; #(
	parameter int PRICE_BITS  = PRICE_BITS_DEFAULT,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         bar_valid,
	output logic         bar_ready,
	input  bar_item_t    bar,
	output logic         result_valid,
	input  logic         result_ready,
	output result_item_t result
);

	// front to queue
	logic      push;
	q_entry_t  push_data;
	// queue to back
	q_status_t qstat;
	q_entry_t  head;
	logic      pop;

	// history, difference stage and compare stage
	cpc_front #(
		.PRICE_BITS (PRICE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.bar_valid (bar_valid),
		.bar_ready (bar_ready),
		.bar       (bar),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	// decouples bar intake from result delivery
	cpc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.qstat     (qstat),
		.head      (head)
	);

	// serializes each match set into result transfers
	cpc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qstat        (qstat),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ----- dv/tb_candlestick_pattern_classifier_top.sv -----
// self-checking testbench for the candlestick pattern classifier top level
module tb_candlestick_pattern_classifier_top;
	import cpc_pkg::*;

	// ------------------------------------------------------------------
	// clock, reset and the two channels
	// ------------------------------------------------------------------
	logic         clk          = 1'b0;
	logic         arst_n       = 1'b0;
	logic         bar_valid    = 1'b0;
	logic         bar_ready;
	bar_item_t    bar          = '0;
	logic         result_valid;
	logic         result_ready = 1'b0;
	result_item_t result;

	candlestick_pattern_classifier_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.bar_valid    (bar_valid),
		.bar_ready    (bar_ready),
		.bar          (bar),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// shadow copy of the bar history, held as signed tick values so the
	// scaled compares below are plain 64-bit integer math
	// ------------------------------------------------------------------
	typedef struct packed {
		longint op;
		longint hi;
		longint lo;
		longint cl;
	} candle_t;

	// bar shapes the random traffic draws from
	typedef enum int {
		SHAPE_DOJI,
		SHAPE_HAMMER,
		SHAPE_STAR,
		SHAPE_MARUBOZU,
		SHAPE_SPIN,
		SHAPE_PLAIN
	} candle_shape_t;

	candle_t      prior_candle = '0;
	candle_t      older_candle = '0;
	int unsigned  bars_held    = 0;
	result_item_t expected_matches[$];

	int unsigned mismatch_count = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;

	function automatic candle_t to_candle(input bar_item_t item);
		candle_t k;
		k.op = longint'({32'd0, item.open_price});
		k.hi = longint'({32'd0, item.high_price});
		k.lo = longint'({32'd0, item.low_price});
		k.cl = longint'({32'd0, item.close_price});
		return k;
	endfunction

	function automatic longint body_len(input candle_t k);
		return (k.cl >= k.op) ? k.cl - k.op : k.op - k.cl;
	endfunction

	function automatic longint span_len(input candle_t k);
		return k.hi - k.lo;
	endfunction

	function automatic logic [6:0] pattern_confidence(input logic [3:0] code);
		case (code)
			PAT_DOJI:                     return 7'd60;
			PAT_HAMMER, PAT_SHOOTING:     return 7'd70;
			PAT_BULL_ENG, PAT_BEAR_ENG:   return 7'd80;
			PAT_WHITE_MAR, PAT_BLACK_MAR: return 7'd65;
			PAT_SPIN_TOP:                 return 7'd50;
			PAT_MORN_STAR:                return 7'd85;
			PAT_SOLDIERS:                 return 7'd90;
			default:                      return 7'd0;
		endcase
	endfunction

	// works out the matches of one accepted bar, queues them in code order,
	// then shifts the bar into the history
	function automatic void predict_matches(input bar_item_t item);
		candle_t      cur;
		candle_t      prv;
		candle_t      old;
		longint       body;
		longint       rng;
		longint       lower;
		longint       upper;
		pat_mask_t    hit;
		int           last_code;
		result_item_t r;
		cur = to_candle(item);
		if (item.starts_series) begin
			bars_held    = 0;
			prior_candle = '0;
			older_candle = '0;
		end
		prv = prior_candle;
		old = older_candle;
		// short history: nothing is tested, the bar is only stored
		if (bars_held >= 2) begin
			body  = body_len(cur);
			rng   = span_len(cur);
			lower = ((cur.cl < cur.op) ? cur.cl : cur.op) - cur.lo;
			upper = cur.hi - ((cur.cl > cur.op) ? cur.cl : cur.op);
			hit   = '0;
			hit[PAT_DOJI]      = rng > 0 && 10 * body <= rng;
			hit[PAT_HAMMER]    = rng > 0 && lower >= 2 * body && 10 * upper <= body;
			hit[PAT_SHOOTING]  = rng > 0 && upper >= 2 * body && 10 * lower <= body;
			hit[PAT_BULL_ENG]  = prv.cl < prv.op && cur.cl > cur.op &&
				cur.op < prv.cl && cur.cl > prv.op;
			hit[PAT_BEAR_ENG]  = prv.cl > prv.op && cur.cl < cur.op &&
				cur.op > prv.cl && cur.cl < prv.op;
			hit[PAT_WHITE_MAR] = rng > 0 && 10 * body > 9 * rng && cur.cl > cur.op;
			hit[PAT_BLACK_MAR] = rng > 0 && 10 * body > 9 * rng && cur.cl < cur.op;
			hit[PAT_SPIN_TOP]  = rng > 0 && 10 * body < 3 * rng &&
				lower > body && upper > body;
			hit[PAT_MORN_STAR] = old.cl < old.op &&
				10 * body_len(prv) < 3 * span_len(prv) &&
				cur.cl > cur.op && 2 * cur.cl > old.op + old.cl;
			hit[PAT_SOLDIERS]  = old.cl > old.op && prv.cl > prv.op && cur.cl > cur.op &&
				prv.cl > old.cl && cur.cl > prv.cl &&
				prv.op > old.op && prv.op < old.cl &&
				cur.op > prv.op && cur.op < prv.cl;
			last_code = -1;
			for (int i = 0; i < NUM_PATTERNS; i++) begin
				if (hit[i]) last_code = i;
			end
			for (int i = 0; i < NUM_PATTERNS; i++) begin
				if (hit[i]) begin
					r.match_date   = item.bar_date;
					r.pattern_code = 4'(i);
					r.confidence   = pattern_confidence(4'(i));
					r.last_of_bar  = (i == last_code);
					expected_matches.insert(expected_matches.size(), r);
				end
			end
		end
		older_candle = prior_candle;
		prior_candle = cur;
		if (bars_held < 2) bars_held++;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic longint pick(input longint lo_v, input longint hi_v);
		return lo_v + longint'($urandom_range(32'(hi_v - lo_v)));
	endfunction

	function automatic bar_item_t make_bar(input longint op, input longint hi,
		input longint lo, input longint cl, input bit fresh);
		bar_item_t b;
		b.starts_series = fresh;
		b.bar_date      = $urandom;
		b.open_price    = op[31:0];
		b.high_price    = hi[31:0];
		b.low_price     = lo[31:0];
		b.close_price   = cl[31:0];
		return b;
	endfunction

	// well-formed bar from open, close and the two wick lengths
	function automatic bar_item_t wick_bar(input longint op, input longint cl,
		input longint lw, input longint uw, input bit fresh);
		return make_bar(op, ((op > cl) ? op : cl) + uw, ((op < cl) ? op : cl) - lw, cl, fresh);
	endfunction

	// one bar transfer; entered and left just after a falling edge, so
	// bar_valid stays high from one bar to the next when there is no gap
	task automatic send_bar(input bar_item_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			bar_valid <= 1'b0;
			@(negedge clk);
		end
		bar       <= item;
		bar_valid <= 1'b1;
		do @(posedge clk); while (!bar_ready);
		predict_matches(item);
		@(negedge clk);
	endtask

	task automatic flag_mismatch(input string what, input longint unsigned want,
		input longint unsigned got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $time);
	endtask

	// ------------------------------------------------------------------
	// receiver: random back-pressure, and the check of every result
	// transfer against the oldest pending expectation
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		result_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_matches.size() == 0) begin
				flag_mismatch("result with nothing pending, pattern_code", 0,
					result.pattern_code);
			end else begin
				want = expected_matches.pop_front();
				if (result.match_date !== want.match_date)
					flag_mismatch("match_date", want.match_date, result.match_date);
				if (result.pattern_code !== want.pattern_code)
					flag_mismatch("pattern_code", want.pattern_code, result.pattern_code);
				if (result.confidence !== want.confidence)
					flag_mismatch("confidence", want.confidence, result.confidence);
				if (result.last_of_bar !== want.last_of_bar)
					flag_mismatch("last_of_bar", want.last_of_bar, result.last_of_bar);
			end
		end
	end

	// ------------------------------------------------------------------
	// directed tests
	// ------------------------------------------------------------------

	// first two bars of a series only fill the history; a new series
	// mid-stream starts the count again
	task automatic test_short_history();
		send_bar(make_bar(100, 150, 50, 110, 1'b1));
		send_bar(make_bar(100, 150, 50, 110, 1'b0));
		send_bar(make_bar(100, 150, 50, 110, 1'b0));
		send_bar(make_bar(100, 150, 50, 110, 1'b1));
		send_bar(make_bar(100, 150, 50, 110, 1'b0));
	endtask

	// single-bar shapes, most sitting exactly on their threshold
	task automatic test_single_bar_shapes();
		send_bar(make_bar(100, 150, 50, 110, 1'b0));     // doji, body a tenth of range
		send_bar(make_bar(1000, 1011, 980, 1010, 1'b0)); // hammer, lower wick twice body
		send_bar(make_bar(1010, 1030, 999, 1000, 1'b0)); // shooting star, mirrored
		send_bar(make_bar(200, 210, 200, 210, 1'b0));    // white marubozu, no wicks
		send_bar(make_bar(210, 210, 200, 200, 1'b0));    // black marubozu
		send_bar(make_bar(200, 210, 200, 209, 1'b0));    // body just nine tenths, no marubozu
		send_bar(make_bar(500, 515, 490, 502, 1'b0));    // spinning top
	endtask

	task automatic test_multi_bar_patterns();
		// bullish engulfing: down bar, then an up bar that covers it
		send_bar(make_bar(120, 125, 95, 100, 1'b0));
		send_bar(make_bar(95, 130, 90, 125, 1'b0));
		// bearish engulfing
		send_bar(make_bar(100, 125, 95, 120, 1'b0));
		send_bar(make_bar(125, 130, 90, 95, 1'b0));
		// morning star: long down bar, small star, up bar past the midpoint
		send_bar(make_bar(200, 205, 150, 150, 1'b0));
		send_bar(make_bar(140, 150, 130, 142, 1'b0));
		send_bar(make_bar(145, 190, 140, 185, 1'b0));
		// three white soldiers, each opening inside the body before it
		send_bar(make_bar(100, 130, 95, 120, 1'b0));
		send_bar(make_bar(110, 145, 105, 140, 1'b0));
		send_bar(make_bar(130, 165, 125, 160, 1'b0));
	endtask

	// full-scale prices, zero range and malformed bars with low above high
	task automatic test_price_extremes();
		bar_item_t b;
		b = make_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		b.bar_date = '1;
		send_bar(b);
		b = make_bar(0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1'b0);
		b.bar_date = '0;
		send_bar(b);
		send_bar(make_bar(32'h8000_0000, 0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0));
		send_bar(make_bar(0, 0, 0, 0, 1'b0));
	endtask

	// ------------------------------------------------------------------
	// random traffic: mostly well-formed pattern sequences and shaped bars
	// around a random price level, the rest raw noise
	// ------------------------------------------------------------------
	task automatic test_random_traffic(input int unsigned items, input int unsigned idle_pct,
		input int unsigned stall_pct);
		int unsigned sent;
		int unsigned roll;
		longint      mid;
		longint      s;
		longint      x;
		longint      nudge;
		longint      po;
		longint      pc;
		longint      lw;
		longint      bd;
		longint      uw;
		bit          fresh;
		bit          up;
		bar_item_t   noise;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < items) begin
			roll  = $urandom_range(99);
			mid   = pick(64'h0100_0000, 64'hFE00_0000);
			s     = ($urandom_range(3) == 0) ? pick(1, 1 << 20) : pick(1, 200);
			fresh = ($urandom_range(19) == 0);
			// now and then the closing bar of a sequence is pulled off target
			nudge = ($urandom_range(4) == 0) ? pick(0, 2 * s) : 0;
			if (roll < 15) begin
				x = pick(1, s);
				if ($urandom_range(1)) begin
					send_bar(wick_bar(mid + x, mid, pick(0, s), pick(0, s), fresh));
					send_bar(wick_bar(mid - pick(1, s), mid + x + pick(1, s) - nudge,
						pick(0, s), pick(0, s), 1'b0));
				end else begin
					send_bar(wick_bar(mid, mid + x, pick(0, s), pick(0, s), fresh));
					send_bar(wick_bar(mid + x + pick(1, s), mid - pick(1, s) + nudge,
						pick(0, s), pick(0, s), 1'b0));
				end
				sent += 2;
			end else if (roll < 30) begin
				// morning star: x is the long first body, bd the star body
				x  = pick(2, 4 * s + 2);
				bd = pick(0, s / 4);
				send_bar(wick_bar(mid + x, mid, pick(0, s), pick(0, s), fresh));
				send_bar(wick_bar(mid - s, mid - s + bd, pick(2 * bd + 1, 2 * bd + s),
					pick(2 * bd + 1, 2 * bd + s), 1'b0));
				send_bar(wick_bar(mid - pick(0, s), mid + x / 2 + pick(1, s) - nudge,
					pick(0, s), pick(0, s), 1'b0));
				sent += 3;
			end else if (roll < 45) begin
				// three soldiers: each bar opens inside the body before it
				x  = pick(2, s + 2);
				po = mid + pick(1, x - 1);
				pc = mid + x + pick(1, s);
				send_bar(wick_bar(mid, mid + x, pick(0, s), pick(0, s), fresh));
				send_bar(wick_bar(po, pc, pick(0, s), pick(0, s), 1'b0));
				send_bar(wick_bar(pick(po + 1, pc - 1), pc + pick(1, s) - nudge,
					pick(0, s), pick(0, s), 1'b0));
				sent += 3;
			end else if (roll < 85) begin
				up = $urandom_range(1);
				case (candle_shape_t'($urandom_range(int'(SHAPE_PLAIN))))
					SHAPE_DOJI: begin
						bd = pick(0, s / 10);
						lw = pick(s / 2, s);
						uw = pick(s / 2, s);
					end
					SHAPE_HAMMER: begin
						bd = pick(1, s);
						lw = pick(2 * bd, 3 * bd + s);
						uw = pick(0, bd / 10);
					end
					SHAPE_STAR: begin
						bd = pick(1, s);
						uw = pick(2 * bd, 3 * bd + s);
						lw = pick(0, bd / 10);
					end
					SHAPE_MARUBOZU: begin
						bd = pick(s, 2 * s);
						lw = pick(0, bd / 25);
						uw = pick(0, bd / 25);
					end
					SHAPE_SPIN: begin
						bd = pick(0, s / 4);
						lw = pick(2 * bd + 1, 2 * bd + s);
						uw = pick(2 * bd + 1, 2 * bd + s);
					end
					default: begin
						bd = pick(0, s);
						lw = pick(0, s);
						uw = pick(0, s);
					end
				endcase
				send_bar(wick_bar(up ? mid : mid + bd, up ? mid + bd : mid, lw, uw, fresh));
				sent += 1;
			end else begin
				// raw noise, malformed bars and series restarts included
				noise.starts_series = ($urandom_range(3) == 0);
				noise.bar_date      = $urandom;
				noise.open_price    = $urandom;
				noise.high_price    = $urandom;
				noise.low_price     = $urandom;
				noise.close_price   = $urandom;
				send_bar(noise);
				sent += 1;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned waited;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_short_history();
		test_single_bar_shapes();
		test_multi_bar_patterns();
		test_price_extremes();

		// idling phases: none, sender gaps, receiver stalls, light mix
		test_random_traffic(96, 0, 0);
		test_random_traffic(96, 87, 0);
		test_random_traffic(96, 0, 87);
		test_random_traffic(96, 9, 9);

		// no more transfers; let the results drain, then keep clocking to catch
		// anything the block sends beyond what was predicted
		bar_valid      <= 1'b0;
		recv_stall_pct  = 0;
		waited = 0;
		while (expected_matches.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);

		if (expected_matches.size() != 0)
			$display("%0d expected results never arrived", expected_matches.size());
		if (mismatch_count == 0 && expected_matches.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- files.f -----
sv/cpc_pkg.sv
sv/cpc_front.sv
sv/cpc_queue.sv
sv/cpc_back.sv
sv/candlestick_pattern_classifier_top.sv
dv/tb_candlestick_pattern_classifier_top.sv
